// ===== sv/assert_macros.svh =====
// Assertion helpers for the checker of this block.
// Both expect i_clk and i_rst_n in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LSTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define LSTC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lstc_pkg.sv =====
package lstc_pkg;

    // grid size
    localparam int TILE_COLS = 8;
    localparam int TILE_ROWS = 8;

    // fixed field widths
    localparam int COORD_W   = 21;
    localparam int PAGE_W    = 20;
    localparam int IDX_W     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_PAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_HEIGHT = 1'b1;

    localparam logic [PAGE_W-1:0] PAGE_WIDTH_RST  = 20'd121000;
    localparam logic [PAGE_W-1:0] PAGE_HEIGHT_RST = 20'd90750;

    // internal widths: tile index, divider magnitude, walk value
    localparam int TW     = 28;
    localparam int DW     = 32;
    localparam int FW     = 34;
    localparam int STEP_W = 6;
    localparam int CNT_W  = $clog2(DW + 1);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [TW-1:0]      t_tile;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_COLS,
        PH_ROWS,
        PH_VERT
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EPLOAD,
        S_EPDIV,
        S_SETUP,
        S_PASS,
        S_WDIV,
        S_VISIT,
        S_CLOSE
    } t_state;

endpackage

// ===== sv/lstc_if.sv =====
interface lstc_seg_if;
    logic                  valid;
    logic                  ready;
    lstc_pkg::t_coord      start_x;
    lstc_pkg::t_coord      start_y;
    lstc_pkg::t_coord      end_x;
    lstc_pkg::t_coord      end_y;

    modport source (output valid, output start_x, output start_y,
                    output end_x, output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y,
                    input end_x, input end_y, output ready);
endinterface

interface lstc_tile_if;
    logic                        valid;
    logic                        ready;
    logic [lstc_pkg::IDX_W-1:0]  tile_col;
    logic [lstc_pkg::IDX_W-1:0]  tile_row;
    logic                        tile_valid;
    logic                        status;
    logic                        last;

    modport source (output valid, output tile_col, output tile_row,
                    output tile_valid, output status, output last, input ready);
    modport sink   (input valid, input tile_col, input tile_row,
                    input tile_valid, input status, input last, output ready);
endinterface

// ===== sv/line_segment_tile_cover.sv =====
// Channel   Dir  Beat contents
// i_seg     in   start_x, start_y, end_x, end_y (21-bit signed world coords)
// o_tile    out  tile_col, tile_row, tile_valid, status, last
// i_cfg_*   in   write enable, register index, 20-bit data (page width/height)
//
// One segment at a time. Four endpoint divisions run first, then every column
// or row step of a sloped walk runs a division on the same restoring divider
// before the tiles of that step are checked.
// Reset is synchronous, active low. The column pass keeps one row span per
// column; the row pass skips tiles inside those spans, so no tile repeats.
// A stalled output holds the sequencer at the next tile.
module line_segment_tile_cover (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    lstc_seg_if.sink                            i_seg,
    lstc_tile_if.source                         o_tile,
    input  logic                                i_cfg_we,
    input  logic [lstc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lstc_pkg::PAGE_W-1:0]         i_cfg_data
);

    localparam int TW = lstc_pkg::TW;
    localparam int DW = lstc_pkg::DW;
    localparam int FW = lstc_pkg::FW;
    localparam int PW = lstc_pkg::PAGE_W;
    localparam int SW = lstc_pkg::STEP_W;

    // control
    lstc_pkg::t_state r_state, n_state;
    lstc_pkg::t_phase r_phase, n_phase;
    logic [1:0]       r_ep, n_ep;
    logic [PW-1:0]    r_page_w, n_page_w, r_page_h, n_page_h;
    logic             r_status, n_status;
    logic             r_ov, n_ov;

    // column pass footprint: floor row per column, plus one row when fractional
    logic [lstc_pkg::IDX_W-1:0]   r_crow [lstc_pkg::TILE_COLS];
    logic [lstc_pkg::IDX_W-1:0]   n_crow [lstc_pkg::TILE_COLS];
    logic [lstc_pkg::TILE_COLS-1:0] r_cspan, n_cspan;

    // endpoint coords and tile indices (x1, y1, x2, y2)
    lstc_pkg::t_coord r_coord [4];
    lstc_pkg::t_coord n_coord [4];
    lstc_pkg::t_tile  r_ept [4];
    lstc_pkg::t_tile  n_ept [4];

    // shared divider
    logic [DW-1:0]    r_dq, n_dq;
    logic [PW-1:0]    r_rem, n_rem, r_den, n_den;
    logic             r_neg, n_neg;
    logic [lstc_pkg::CNT_W-1:0] r_cnt, n_cnt;

    // walk
    lstc_pkg::t_tile  r_i, n_i, r_hi, n_hi, r_a1, n_a1, r_b1, n_b1;
    logic signed [TW:0] r_da, n_da, r_db, n_db;
    logic signed [FW-1:0] r_f, n_f;
    logic             r_frac, n_frac;

    // output register
    logic [lstc_pkg::IDX_W-1:0] r_ocol, n_ocol, r_orow, n_orow;
    logic             r_otv, n_otv, r_ost, n_ost, r_olast, n_olast;

    // combinational helpers
    lstc_pkg::t_coord  ep_c;
    logic [lstc_pkg::COORD_W:0] ep_ext, ep_abs;
    logic [DW-1:0]     ep_mult, ep_mag, ep_qs;
    logic [PW-1:0]     den_page;
    logic [PW:0]       rem_sh, rem_diff;
    logic              div_ge;
    logic signed [SW-1:0] sd;
    logic signed [TW+SW:0] num_full;
    logic [TW+SW:0]    num_abs;
    logic              num_neg;
    logic signed [TW:0] da_abs;
    logic              w_frac;
    logic [FW-1:0]     qe, w_qs;
    logic signed [FW-1:0] b1_ext, w_f, i_ext, vcol, vrow;
    logic              v_in, out_free;
    logic [lstc_pkg::IDX_W-1:0] vc3, vr3;
    logic              seen;
    lstc_pkg::t_tile   x1, y1, x2, y2, lo_x, hi_x, lo_y, hi_y;
    logic signed [TW:0] dx, dy;

    assign i_seg.ready       = (r_state == lstc_pkg::S_IDLE);
    assign o_tile.valid      = r_ov;
    assign o_tile.tile_col   = r_ocol;
    assign o_tile.tile_row   = r_orow;
    assign o_tile.tile_valid = r_otv;
    assign o_tile.status     = r_ost;
    assign o_tile.last       = r_olast;

    always_comb begin
        // endpoint dividend: |coord| * tile count, divisor: page size (zero reads as one)
        ep_c     = r_coord[r_ep];
        ep_ext   = {ep_c[lstc_pkg::COORD_W-1], ep_c};
        ep_abs   = ep_c[lstc_pkg::COORD_W-1] ? (~ep_ext + 1'b1) : ep_ext;
        ep_mult  = r_ep[0] ? DW'(lstc_pkg::TILE_ROWS) : DW'(lstc_pkg::TILE_COLS);
        ep_mag   = DW'(ep_abs) * ep_mult;
        den_page = r_ep[0] ? r_page_h : r_page_w;
        if (den_page == '0) begin
            den_page = PW'(1);
        end

        // one restoring step
        rem_sh   = {r_rem, r_dq[DW-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        div_ge   = !rem_diff[PW];

        // truncated endpoint quotient
        ep_qs = r_neg ? (~r_dq + 1'b1) : r_dq;

        // walk step numerator: db * (i - a1), denominator |da|
        sd       = SW'(r_i - r_a1);
        num_full = r_db * sd;
        num_neg  = num_full[TW+SW];
        num_abs  = num_neg ? (~num_full + 1'b1) : num_full;
        da_abs   = r_da[TW] ? -r_da : r_da;

        // floored walk quotient added to b1
        w_frac = (r_rem != '0);
        qe     = FW'(r_dq);
        w_qs   = r_neg ? (~(qe + FW'(w_frac)) + 1'b1) : qe;
        b1_ext = FW'(r_b1);
        w_f    = b1_ext + $signed(w_qs);

        // tile under test
        i_ext = FW'(r_i);
        vcol  = (r_phase == lstc_pkg::PH_COLS) ? i_ext : r_f;
        vrow  = (r_phase == lstc_pkg::PH_COLS) ? r_f : i_ext;
        v_in  = (vcol >= 0) && (vcol <= lstc_pkg::TILE_COLS - 1) &&
                (vrow >= 0) && (vrow <= lstc_pkg::TILE_ROWS - 1);

        x1   = r_ept[0];
        y1   = r_ept[1];
        x2   = r_ept[2];
        y2   = r_ept[3];
        dx   = (TW+1)'(x2) - (TW+1)'(x1);
        dy   = (TW+1)'(y2) - (TW+1)'(y1);
        lo_x = (x1 < x2) ? x1 : x2;
        hi_x = (x1 < x2) ? x2 : x1;
        lo_y = (y1 < y2) ? y1 : y2;
        hi_y = (y1 < y2) ? y2 : y1;

        // only the row pass can meet a tile already sent, and only one the
        // column pass sent at that column
        vc3  = vcol[lstc_pkg::IDX_W-1:0];
        vr3  = vrow[lstc_pkg::IDX_W-1:0];
        seen = (r_phase == lstc_pkg::PH_ROWS) &&
               (vcol >= FW'(lo_x)) && (vcol <= FW'(hi_x)) &&
               ((vr3 == r_crow[vc3]) ||
                (r_cspan[vc3] && (vr3 == r_crow[vc3] + 1'b1)));

        out_free = !r_ov || o_tile.ready;

        // defaults
        n_state   = r_state;
        n_phase   = r_phase;
        n_ep      = r_ep;
        n_page_w  = r_page_w;
        n_page_h  = r_page_h;
        n_crow    = r_crow;
        n_cspan   = r_cspan;
        n_status  = r_status;
        n_coord   = r_coord;
        n_ept     = r_ept;
        n_dq      = r_dq;
        n_rem     = r_rem;
        n_den     = r_den;
        n_neg     = r_neg;
        n_cnt     = r_cnt;
        n_i       = r_i;
        n_hi      = r_hi;
        n_a1      = r_a1;
        n_b1      = r_b1;
        n_da      = r_da;
        n_db      = r_db;
        n_f       = r_f;
        n_frac    = r_frac;
        n_ov      = r_ov && !o_tile.ready;
        n_ocol    = r_ocol;
        n_orow    = r_orow;
        n_otv     = r_otv;
        n_ost     = r_ost;
        n_olast   = r_olast;

        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lstc_pkg::REG_PAGE_WIDTH:  n_page_w = i_cfg_data;
                lstc_pkg::REG_PAGE_HEIGHT: n_page_h = i_cfg_data;
                default: ;
            endcase
        end

        if (r_cnt != '0) begin
            n_rem = div_ge ? rem_diff[PW-1:0] : rem_sh[PW-1:0];
            n_dq  = {r_dq[DW-2:0], div_ge};
            n_cnt = r_cnt - 1'b1;
        end

        unique case (r_state)
            lstc_pkg::S_IDLE: begin
                if (i_seg.valid) begin
                    n_coord[0] = i_seg.start_x;
                    n_coord[1] = i_seg.start_y;
                    n_coord[2] = i_seg.end_x;
                    n_coord[3] = i_seg.end_y;
                    n_ep       = 2'd0;
                    n_status   = 1'b0;
                    n_state    = lstc_pkg::S_EPLOAD;
                end
            end
            lstc_pkg::S_EPLOAD: begin
                n_dq    = ep_mag;
                n_rem   = '0;
                n_den   = den_page;
                n_neg   = ep_c[lstc_pkg::COORD_W-1];
                n_cnt   = lstc_pkg::CNT_W'(DW);
                n_state = lstc_pkg::S_EPDIV;
            end
            lstc_pkg::S_EPDIV: begin
                if (r_cnt == '0) begin
                    n_ept[r_ep] = ep_qs[TW-1:0];
                    n_ep        = r_ep + 1'b1;
                    n_state     = (r_ep == 2'd3) ? lstc_pkg::S_SETUP : lstc_pkg::S_EPLOAD;
                end
            end
            lstc_pkg::S_SETUP: begin
                if (dx == '0) begin
                    // vertical: one column, rows lo..hi
                    n_phase = lstc_pkg::PH_VERT;
                    n_f     = FW'(x1);
                    n_frac  = 1'b0;
                    n_i     = lo_y;
                    n_hi    = hi_y;
                    n_state = lstc_pkg::S_VISIT;
                end else begin
                    n_phase = lstc_pkg::PH_COLS;
                    if (lo_x < 0 || hi_x > lstc_pkg::TILE_COLS - 1) begin
                        n_status = 1'b1;
                        n_state  = lstc_pkg::S_CLOSE;
                    end else begin
                        n_a1    = x1;
                        n_b1    = y1;
                        n_da    = dx;
                        n_db    = dy;
                        n_i     = lo_x;
                        n_hi    = hi_x;
                        n_state = lstc_pkg::S_PASS;
                    end
                end
            end
            lstc_pkg::S_PASS: begin
                n_dq    = DW'(num_abs);
                n_rem   = '0;
                n_den   = PW'(da_abs);
                n_neg   = num_neg ^ r_da[TW];
                n_cnt   = lstc_pkg::CNT_W'(DW);
                n_state = lstc_pkg::S_WDIV;
            end
            lstc_pkg::S_WDIV: begin
                if (r_cnt == '0) begin
                    n_f     = w_f;
                    n_frac  = w_frac;
                    if (r_phase == lstc_pkg::PH_COLS) begin
                        n_crow[r_i[lstc_pkg::IDX_W-1:0]]  = w_f[lstc_pkg::IDX_W-1:0];
                        n_cspan[r_i[lstc_pkg::IDX_W-1:0]] = w_frac;
                    end
                    n_state = lstc_pkg::S_VISIT;
                end
            end
            lstc_pkg::S_VISIT: begin
                if (!v_in) begin
                    n_status = 1'b1;
                    n_state  = lstc_pkg::S_CLOSE;
                end else if (seen || out_free) begin
                    if (!seen) begin
                        n_ov    = 1'b1;
                        n_ocol  = vc3;
                        n_orow  = vr3;
                        n_otv   = 1'b1;
                        n_ost   = 1'b0;
                        n_olast = 1'b0;
                    end
                    if (r_frac) begin
                        // floor visited, now the ceil
                        n_frac = 1'b0;
                        n_f    = r_f + 1'b1;
                    end else if (r_i != r_hi) begin
                        n_i     = r_i + 1'b1;
                        n_state = (r_phase == lstc_pkg::PH_VERT) ?
                                  lstc_pkg::S_VISIT : lstc_pkg::S_PASS;
                    end else if (r_phase == lstc_pkg::PH_COLS && r_db != '0) begin
                        n_phase = lstc_pkg::PH_ROWS;
                        if (lo_y < 0 || hi_y > lstc_pkg::TILE_ROWS - 1) begin
                            n_status = 1'b1;
                            n_state  = lstc_pkg::S_CLOSE;
                        end else begin
                            n_a1    = y1;
                            n_b1    = x1;
                            n_da    = dy;
                            n_db    = dx;
                            n_i     = lo_y;
                            n_hi    = hi_y;
                            n_state = lstc_pkg::S_PASS;
                        end
                    end else begin
                        n_state = lstc_pkg::S_CLOSE;
                    end
                end
            end
            lstc_pkg::S_CLOSE: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_ocol  = '0;
                    n_orow  = '0;
                    n_otv   = 1'b0;
                    n_ost   = r_status;
                    n_olast = 1'b1;
                    n_phase = lstc_pkg::PH_IDLE;
                    n_state = lstc_pkg::S_IDLE;
                end
            end
            default: n_state = lstc_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= lstc_pkg::S_IDLE;
            r_phase   <= lstc_pkg::PH_IDLE;
            r_ep      <= 2'd0;
            r_page_w  <= lstc_pkg::PAGE_WIDTH_RST;
            r_page_h  <= lstc_pkg::PAGE_HEIGHT_RST;
            r_status  <= 1'b0;
            r_ov      <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_ep      <= n_ep;
            r_page_w  <= n_page_w;
            r_page_h  <= n_page_h;
            r_status  <= n_status;
            r_ov      <= n_ov;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_coord <= n_coord;
        r_ept   <= n_ept;
        r_crow  <= n_crow;
        r_cspan <= n_cspan;
        r_dq    <= n_dq;
        r_rem   <= n_rem;
        r_den   <= n_den;
        r_neg   <= n_neg;
        r_i     <= n_i;
        r_hi    <= n_hi;
        r_a1    <= n_a1;
        r_b1    <= n_b1;
        r_da    <= n_da;
        r_db    <= n_db;
        r_f     <= n_f;
        r_frac  <= n_frac;
        r_ocol  <= n_ocol;
        r_orow  <= n_orow;
        r_otv   <= n_otv;
        r_ost   <= n_ost;
        r_olast <= n_olast;
    end

endmodule

// ===== sv/lstc_checker.sv =====
`include "assert_macros.svh"

module lstc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_seg_valid,
    input logic                       i_seg_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [lstc_pkg::IDX_W-1:0] i_out_col,
    input logic [lstc_pkg::IDX_W-1:0] i_out_row,
    input logic                       i_out_tile_valid,
    input logic                       i_out_status,
    input logic                       i_out_last
);

    // one segment at a time
    `LSTC_ASSERT_NXT(a_busy_after_accept, i_seg_valid && i_seg_ready, !i_seg_ready,
        "input still ready after a segment beat")

    // a tile beat still waiting means the run is not over
    `LSTC_ASSERT_IMP(a_tile_before_idle, i_out_valid && !i_out_last, !i_seg_ready,
        "ready for a new segment while its tiles are pending")

    // tile beats carry no status and no last, closing beats carry last
    `LSTC_ASSERT_IMP(a_item_kind, i_out_valid,
        (i_out_tile_valid && !i_out_last && !i_out_status) ||
        (!i_out_tile_valid && i_out_last),
        "tile and closing beat fields disagree")

    `LSTC_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_out_col) && $stable(i_out_row) &&
        $stable(i_out_last) && $stable(i_out_status),
        "stalled output beat changed")

endmodule

bind line_segment_tile_cover lstc_checker u_lstc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_seg_valid      (i_seg.valid),
    .i_seg_ready      (i_seg.ready),
    .i_out_valid      (o_tile.valid),
    .i_out_ready      (o_tile.ready),
    .i_out_col        (o_tile.tile_col),
    .i_out_row        (o_tile.tile_row),
    .i_out_tile_valid (o_tile.tile_valid),
    .i_out_status     (o_tile.status),
    .i_out_last       (o_tile.last)
);

// ===== tb/lstc_tb_if.sv =====
// Extra verification-side channel interfaces are not needed: the RTL provides
// lstc_seg_if and lstc_tile_if. This file holds a small bundle for the
// register write port so the testbench drives it through one handle.
interface lstc_cfg_if;
    logic                           we;
    logic [lstc_pkg::CFG_IDX_W-1:0] idx;
    logic [lstc_pkg::PAGE_W-1:0]    data;
endinterface

// ===== tb/line_segment_tile_cover_test.sv =====
module line_segment_tile_cover_test;
    timeunit 1ns;
    timeprecision 1ps;

    // one expected output beat
    typedef struct packed {
        logic [lstc_pkg::IDX_W-1:0] col;
        logic [lstc_pkg::IDX_W-1:0] row;
        logic             tvalid;
        logic             status;
        logic             last;
    } t_tile_beat;

    typedef struct packed {
        lstc_pkg::t_coord sx, sy, ex, ey;
    } t_segment;

    logic i_clk, i_rst_n;
    lstc_seg_if  seg ();
    lstc_tile_if tile ();
    lstc_cfg_if  cfg ();

    line_segment_tile_cover DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_seg      (seg.sink),
        .o_tile     (tile.source),
        .i_cfg_we   (cfg.we),
        .i_cfg_idx  (cfg.idx),
        .i_cfg_data (cfg.data)
    );

    // predictor copy of the page registers
    logic [lstc_pkg::PAGE_W-1:0] mdl_page_w, mdl_page_h;
    bit                mdl_seen [lstc_pkg::TILE_COLS*lstc_pkg::TILE_ROWS];
    t_tile_beat        tiles_due [$];
    t_segment          segs_pending [$];

    int  n_errors;
    int  send_idle_pct, recv_idle_pct;
    int  hold_off;          // receiver long stall, counted down by the monitor
    int  quiet_cycles;
    bit  seg_acc;           // input beat taken at the last rising edge

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what, input t_tile_beat got, input t_tile_beat exp);
        $display("MISMATCH %s: got c%0d r%0d v%0b s%0b l%0b, want c%0d r%0d v%0b s%0b l%0b",
                 what, got.col, got.row, got.tvalid, got.status, got.last,
                 exp.col, exp.row, exp.tvalid, exp.status, exp.last);
        n_errors++;
    endtask

    // ---------------------------------------------------------------
    // Predictor: exact rational walk over the tile grid.
    // ---------------------------------------------------------------
    function automatic longint floor_q(longint num, longint den);
        longint q;
        q = num / den;
        if ((num % den) != 0 && num < 0) q -= 1;
        return q;
    endfunction

    // record a tile; returns 0 when the tile is off the grid (abort)
    function automatic bit mark_tile(longint c, longint r);
        t_tile_beat b;
        int k;
        if (c < 0 || r < 0 || c > lstc_pkg::TILE_COLS-1 || r > lstc_pkg::TILE_ROWS-1)
            return 1'b0;
        k = int'(c) * lstc_pkg::TILE_ROWS + int'(r);
        if (!mdl_seen[k]) begin
            mdl_seen[k] = 1'b1;
            b = '{col: c[lstc_pkg::IDX_W-1:0], row: r[lstc_pkg::IDX_W-1:0], tvalid: 1'b1,
                  status: 1'b0, last: 1'b0};
            tiles_due.push_back(b);
        end
        return 1'b1;
    endfunction

    // one pass along the major axis a (columns or rows); returns 0 on abort
    function automatic bit walk_axis(longint a1, longint b1, longint da, longint db,
                                     longint lo, longint hi, bit by_cols);
        longint num, den, f;
        for (longint i = lo; i <= hi; i++) begin
            num = db * (i - a1);
            den = da;
            if (den < 0) begin
                num = -num;
                den = -den;
            end
            f = b1 + floor_q(num, den);
            if (num % den != 0) begin
                if (!(by_cols ? mark_tile(i, f) : mark_tile(f, i))) return 1'b0;
                f += 1;
            end
            if (!(by_cols ? mark_tile(i, f) : mark_tile(f, i))) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit walk_segment(longint x1, longint y1, longint x2, longint y2);
        longint dx, dy, lo, hi;
        dx = x2 - x1;
        dy = y2 - y1;
        if (dx == 0) begin
            lo = (y1 < y2) ? y1 : y2;
            hi = (y1 < y2) ? y2 : y1;
            for (longint i = lo; i <= hi; i++)
                if (!mark_tile(x1, i)) return 1'b0;
            return 1'b1;
        end
        lo = (x1 < x2) ? x1 : x2;
        hi = (x1 < x2) ? x2 : x1;
        if (lo < 0 || hi > lstc_pkg::TILE_COLS-1) return 1'b0;
        if (!walk_axis(x1, y1, dx, dy, lo, hi, 1'b1)) return 1'b0;
        if (dy != 0) begin
            lo = (y1 < y2) ? y1 : y2;
            hi = (y1 < y2) ? y2 : y1;
            if (lo < 0 || hi > lstc_pkg::TILE_ROWS-1) return 1'b0;
            if (!walk_axis(y1, x1, dy, dx, lo, hi, 1'b0)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_cover(t_segment s);
        longint pw, ph, x1, y1, x2, y2;
        bit ok;
        t_tile_beat b;
        pw = (mdl_page_w == 0) ? 1 : longint'(mdl_page_w);
        ph = (mdl_page_h == 0) ? 1 : longint'(mdl_page_h);
        // truncating division toward zero, as the endpoint mapping defines
        x1 = longint'(s.sx) * lstc_pkg::TILE_COLS / pw;
        y1 = longint'(s.sy) * lstc_pkg::TILE_ROWS / ph;
        x2 = longint'(s.ex) * lstc_pkg::TILE_COLS / pw;
        y2 = longint'(s.ey) * lstc_pkg::TILE_ROWS / ph;
        foreach (mdl_seen[k]) mdl_seen[k] = 1'b0;
        ok = walk_segment(x1, y1, x2, y2);
        b = '{col: '0, row: '0, tvalid: 1'b0, status: !ok, last: 1'b1};
        tiles_due.push_back(b);
    endfunction

    // ---------------------------------------------------------------
    // Driver: offers queued segments at the falling edge.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            seg.valid <= 1'b0;
        end else if (seg.valid && !seg_acc) begin
            // hold the beat until taken
        end else if (segs_pending.size() != 0 &&
                     $urandom_range(99) >= send_idle_pct) begin
            seg.valid   <= 1'b1;
            seg.start_x <= segs_pending[0].sx;
            seg.start_y <= segs_pending[0].sy;
            seg.end_x   <= segs_pending[0].ex;
            seg.end_y   <= segs_pending[0].ey;
        end else begin
            seg.valid <= 1'b0;
        end
    end

    // accept side of the input channel: predict on each accepted beat
    always @(posedge i_clk) begin
        seg_acc <= i_rst_n && seg.valid && seg.ready;
        if (i_rst_n && seg.valid && seg.ready) begin
            predict_cover(segs_pending.pop_front());
        end
    end

    // ---------------------------------------------------------------
    // Monitor and receiver stall control.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            tile.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off   <= hold_off - 1;
            tile.ready <= 1'b0;
        end else begin
            tile.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_tile_beat got, exp;
        if (i_rst_n && tile.valid && tile.ready) begin
            got = '{col: tile.tile_col, row: tile.tile_row, tvalid: tile.tile_valid,
                    status: tile.status, last: tile.last};
            if (tiles_due.size() == 0) begin
                report("unexpected beat", got, got);
            end else begin
                exp = tiles_due.pop_front();
                if (got.col !== exp.col) report("tile_col", got, exp);
                if (got.row !== exp.row) report("tile_row", got, exp);
                if (got.tvalid !== exp.tvalid) report("tile_valid", got, exp);
                if (got.status !== exp.status) report("status", got, exp);
                if (got.last !== exp.last) report("last", got, exp);
            end
        end
    end

    // watchdog: slow segments and receiver stalls keep both channels quiet, so it waits long
    always @(posedge i_clk) begin
        if ((seg.valid && seg.ready) || (tile.valid && tile.ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 40000) begin
            $display("line_segment_tile_cover_test: errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic lstc_pkg::t_coord rand_coord();
        return lstc_pkg::t_coord'($urandom);
    endfunction

    // world coordinate landing in tile k of n, given page size p (k may be off-grid)
    function automatic lstc_pkg::t_coord tile_coord(int k, logic [lstc_pkg::PAGE_W-1:0] p,
                                                    int n);
        longint pv, v;
        pv = (p == 0) ? 1 : longint'(p);
        v  = (longint'((k < 0) ? -k : k) * pv + longint'($urandom_range(int'(pv - 1)))) / n;
        if (k < 0) v = -v;
        if (v > 1048575) v = 1048575;
        if (v < -1048576) v = -1048576;
        return lstc_pkg::t_coord'(v);
    endfunction

    task automatic add_seg(lstc_pkg::t_coord sx, lstc_pkg::t_coord sy,
                           lstc_pkg::t_coord ex, lstc_pkg::t_coord ey);
        segs_pending.push_back('{sx: sx, sy: sy, ex: ex, ey: ey});
    endtask

    task automatic add_grid_seg(int c1, int r1, int c2, int r2);
        add_seg(tile_coord(c1, mdl_page_w, lstc_pkg::TILE_COLS),
                tile_coord(r1, mdl_page_h, lstc_pkg::TILE_ROWS),
                tile_coord(c2, mdl_page_w, lstc_pkg::TILE_COLS),
                tile_coord(r2, mdl_page_h, lstc_pkg::TILE_ROWS));
    endtask

    task automatic wait_drained();
        while (segs_pending.size() != 0 || tiles_due.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [lstc_pkg::CFG_IDX_W-1:0] idx,
                             logic [lstc_pkg::PAGE_W-1:0] val);
        @(negedge i_clk);
        cfg.we   <= 1'b1;
        cfg.idx  <= idx;
        cfg.data <= val;
        @(negedge i_clk);
        cfg.we   <= 1'b0;
        if (idx == lstc_pkg::REG_PAGE_WIDTH) mdl_page_w = val;
        else mdl_page_h = val;
    endtask

    // random phase: mostly on-grid segments, some off-grid, some raw noise
    task automatic random_phase(int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 70)
                add_grid_seg($urandom_range(lstc_pkg::TILE_COLS-1),
                             $urandom_range(lstc_pkg::TILE_ROWS-1),
                             $urandom_range(lstc_pkg::TILE_COLS-1),
                             $urandom_range(lstc_pkg::TILE_ROWS-1));
            else if (pick < 80)
                // vertical or horizontal
                if ($urandom_range(1)) begin
                    lstc_pkg::t_coord x;
                    x = tile_coord($urandom_range(lstc_pkg::TILE_COLS-1), mdl_page_w,
                                   lstc_pkg::TILE_COLS);
                    add_seg(x, tile_coord($urandom_range(lstc_pkg::TILE_ROWS-1), mdl_page_h,
                                          lstc_pkg::TILE_ROWS),
                            x, tile_coord($urandom_range(lstc_pkg::TILE_ROWS-1), mdl_page_h,
                                          lstc_pkg::TILE_ROWS));
                end else begin
                    lstc_pkg::t_coord y;
                    y = tile_coord($urandom_range(lstc_pkg::TILE_ROWS-1), mdl_page_h,
                                   lstc_pkg::TILE_ROWS);
                    add_seg(tile_coord($urandom_range(lstc_pkg::TILE_COLS-1), mdl_page_w,
                                       lstc_pkg::TILE_COLS), y,
                            tile_coord($urandom_range(lstc_pkg::TILE_COLS-1), mdl_page_w,
                                       lstc_pkg::TILE_COLS), y);
                end
            else if (pick < 92)
                add_grid_seg(int'($urandom_range(11)) - 2, int'($urandom_range(11)) - 2,
                             int'($urandom_range(11)) - 2, int'($urandom_range(11)) - 2);
            else
                add_seg(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    initial begin
        n_errors      = 0;
        hold_off      = 0;
        quiet_cycles  = 0;
        seg_acc       = 1'b0;
        send_idle_pct = 17;
        recv_idle_pct = 78;
        mdl_page_w    = lstc_pkg::PAGE_WIDTH_RST;
        mdl_page_h    = lstc_pkg::PAGE_HEIGHT_RST;
        seg.valid   = 1'b0;
        seg.start_x = '0;
        seg.start_y = '0;
        seg.end_x   = '0;
        seg.end_y   = '0;
        tile.ready  = 1'b0;
        cfg.we      = 1'b0;
        cfg.idx     = lstc_pkg::REG_PAGE_WIDTH;
        cfg.data    = '0;
        i_rst_n     = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset page sizes, field extremes and named cases
        add_seg(21'sh0FFFFF, 21'sh0FFFFF, 21'sh100000, 21'sh100000); // extremes, abort
        add_seg(21'sh100000, 21'sh0, 21'sh0FFFFF, 21'sh0);
        add_seg('0, '0, '0, '0);                                    // single point
        add_grid_seg(0, 0, 7, 7);                                   // full diagonal
        add_grid_seg(7, 0, 0, 7);
        add_grid_seg(0, 3, 7, 3);                                   // horizontal
        add_grid_seg(5, 0, 5, 7);                                   // vertical
        add_grid_seg(5, 7, 5, 0);
        add_grid_seg(0, 0, 7, 2);                                   // shallow, fractional rows
        add_grid_seg(1, 0, 3, 7);                                   // steep, fractional cols
        add_grid_seg(-1, 2, 4, 5);                                  // column out of range
        add_grid_seg(2, 3, 8, 5);
        add_grid_seg(1, -1, 4, 3);                                  // row off grid, abort in col pass
        add_grid_seg(2, 6, 5, 9);
        add_grid_seg(3, -2, 3, 4);                                  // vertical walking off grid
        add_grid_seg(6, 5, 6, 9);
        add_grid_seg(9, 1, 9, 2);                                   // vertical wide column
        wait_drained();

        // zero page sizes act as one: every nonzero coordinate leaves the grid
        write_reg(lstc_pkg::REG_PAGE_WIDTH, '0);
        write_reg(lstc_pkg::REG_PAGE_HEIGHT, '0);
        add_seg('0, '0, '0, '0);
        add_seg(21'sd0, 21'sd0, 21'sd0, 21'sd1);
        add_seg(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        wait_drained();

        // maximum page size
        write_reg(lstc_pkg::REG_PAGE_WIDTH, 20'hFFFFF);
        write_reg(lstc_pkg::REG_PAGE_HEIGHT, 20'hFFFFF);
        add_grid_seg(0, 7, 7, 0);
        random_phase(40);
        // long receiver stall while the sender keeps offering
        hold_off = 3000;
        wait_drained();

        // small pages: width 64 gives 8 units per column tile, coordinates stay on grid with low bits
        write_reg(lstc_pkg::REG_PAGE_WIDTH, 20'd64);
        write_reg(lstc_pkg::REG_PAGE_HEIGHT, 20'd1);
        random_phase(40);
        wait_drained();

        // sender busy side idles now
        send_idle_pct = 78;
        recv_idle_pct = 17;
        write_reg(lstc_pkg::REG_PAGE_WIDTH, 20'd1000);
        write_reg(lstc_pkg::REG_PAGE_HEIGHT, 20'd777777);
        random_phase(80);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(lstc_pkg::REG_PAGE_WIDTH, lstc_pkg::PAGE_WIDTH_RST);
        write_reg(lstc_pkg::REG_PAGE_HEIGHT, lstc_pkg::PAGE_HEIGHT_RST);
        random_phase(80);
        wait_drained();

        if (n_errors == 0)
            $display("line_segment_tile_cover_test: clean");
        else
            $display("line_segment_tile_cover_test: errors");
        $finish;
    end

endmodule
